>>> sv/wisdp_pkg.sv
package wisdp_pkg;

  localparam int MAX_INTERVALS = 1024;
  localparam int TIME_BITS     = 16;
  localparam int IDX_W         = $clog2(MAX_INTERVALS);
  localparam int CNT_W         = IDX_W + 1;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [0:0] {
    CFG_WINDOW_LOW  = 1'b0,
    CFG_WINDOW_HIGH = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    time_t start_time;
    time_t end_time;
    logic  last_item;
  } item_t;

  typedef struct packed {
    time_t best_total;
    logic  overflow;
  } result_t;

  // request as it travels from front to back
  typedef struct packed {
    time_t start_time;
    time_t end_time;
    logic  keep;
    logic  last_item;
  } qitem_t;

  typedef struct packed {
    time_t end_time;
    time_t start_time;
  } key_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_INS_RD,
    B_INS_CMP,
    B_SOLVE,
    B_DP_RD,
    B_DP_KEY,
    B_BS,
    B_BS_CMP,
    B_BEST_WAIT,
    B_DP_UPD
  } back_state_t;

endpackage

>>> sv/windowed_interval_schedule_dp.sv
// Latency: a request passes through the queue to the back end; a kept interval is
// inserted in sorted order by moving each stored entry it passes up one place.
// Throughput: one request per cycle while the 4-entry queue has room (busy = queue full).
// After the last request the solve pass runs one binary search per stored interval.
// Reset (rst, synchronous): window_low = 0, window_high = all ones, set empty.
// The result is shown one cycle with done high; the receiver cannot stall.
module windowed_interval_schedule_dp import wisdp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result,
  input  logic    cfg_we,
  input  logic    cfg_idx,
  input  time_t   cfg_data
);

  // front-to-back request queue handshake
  logic   q_valid;
  qitem_t q_data;
  logic   q_pop;

  // front: window filter, config registers and request queue
  wisdp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  // back: sorted store, binary-search predecessor, DP over best totals
  wisdp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .done    (done),
    .result  (result)
  );

endmodule

>>> sv/wisdp_front.sv
module wisdp_front import wisdp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  item_t  item,
  output logic   busy,
  input  logic   cfg_we,
  input  logic   cfg_idx,
  input  time_t  cfg_data,
  output logic   q_valid,
  output qitem_t q_data,
  input  logic   q_pop
);

  time_t window_low;
  time_t window_high;

  qitem_t            fifo [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   cnt;

  logic   keep;
  logic   push;
  qitem_t push_data;

  assign busy = (cnt == QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
  assign keep = (item.start_time >= window_low) && (item.end_time <= window_high) &&
                (item.end_time >= item.start_time);
  // rejected items only matter when they close the set
  assign push = start && !busy && (keep || item.last_item);
  assign push_data = '{start_time: item.start_time, end_time: item.end_time,
                       keep: keep, last_item: item.last_item};

  assign q_valid = (cnt != '0);
  assign q_data  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_low  <= '0;
      window_high <= '1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_WINDOW_LOW:  window_low  <= cfg_data;
        CFG_WINDOW_HIGH: window_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        cnt <= cnt + 1'b1;
      end else if (!push && q_pop) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

>>> sv/wisdp_back.sv
module wisdp_back import wisdp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  qitem_t  q_data,
  output logic    q_pop,
  output logic    done,
  output result_t result
);

  key_t  key_mem  [MAX_INTERVALS];
  time_t best_mem [MAX_INTERVALS];
  key_t  key_q;
  time_t best_q;

  back_state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             ovf, ovf_next;
  logic [CNT_W-1:0] pos, pos_next;
  key_t             new_key, new_key_next;
  logic             last_q, last_q_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] lo, lo_next;
  logic [CNT_W-1:0] hi, hi_next;
  time_t            s_i, s_i_next;
  time_t            take, take_next;
  time_t            prev, prev_next;
  logic             done_next;
  result_t          result_next;

  logic             kw_en;
  logic [IDX_W-1:0] kw_addr;
  key_t             kw_data;
  logic [IDX_W-1:0] kr_addr;
  logic             bw_en;
  logic [IDX_W-1:0] bw_addr;
  time_t            bw_data;
  logic [IDX_W-1:0] br_addr;

  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] pos_m1;
  logic [CNT_W-1:0] lo_m1;
  logic             in_order;
  time_t            best_i;

  assign mid    = (lo + hi) >> 1;
  assign pos_m1 = pos - 1'b1;
  assign lo_m1  = lo - 1'b1;
  // stored entry may stay ahead of the new one
  assign in_order = (key_q.end_time < new_key.end_time) ||
                    ((key_q.end_time == new_key.end_time) &&
                     (key_q.start_time <= new_key.start_time));
  assign best_i = (prev > take) ? prev : take;

  always_ff @(posedge clk) begin
    if (kw_en) begin
      key_mem[kw_addr] <= kw_data;
    end
    key_q <= key_mem[kr_addr];
  end

  always_ff @(posedge clk) begin
    if (bw_en) begin
      best_mem[bw_addr] <= bw_data;
    end
    best_q <= best_mem[br_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      count <= '0;
      ovf   <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    new_key <= new_key_next;
    last_q  <= last_q_next;
    idx     <= idx_next;
    lo      <= lo_next;
    hi      <= hi_next;
    s_i     <= s_i_next;
    take    <= take_next;
    prev    <= prev_next;
    result  <= result_next;
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    ovf_next     = ovf;
    pos_next     = pos;
    new_key_next = new_key;
    last_q_next  = last_q;
    idx_next     = idx;
    lo_next      = lo;
    hi_next      = hi;
    s_i_next     = s_i;
    take_next    = take;
    prev_next    = prev;
    done_next    = 1'b0;
    result_next  = result;
    q_pop        = 1'b0;
    kw_en        = 1'b0;
    kw_addr      = pos[IDX_W-1:0];
    kw_data      = new_key;
    kr_addr      = pos_m1[IDX_W-1:0];
    bw_en        = 1'b0;
    bw_addr      = idx[IDX_W-1:0];
    bw_data      = best_i;
    br_addr      = lo_m1[IDX_W-1:0];

    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          last_q_next  = q_data.last_item;
          new_key_next = '{end_time: q_data.end_time, start_time: q_data.start_time};
          pos_next     = count;
          if (q_data.keep && (count == CNT_W'(MAX_INTERVALS))) begin
            ovf_next = 1'b1;
            if (q_data.last_item) begin
              state_next = B_SOLVE;
            end
          end else if (q_data.keep) begin
            state_next = B_INS_RD;
          end else begin
            state_next = B_SOLVE;
          end
        end
      end

      // insertion: read the entry below the hole
      B_INS_RD: begin
        if (pos == '0) begin
          kw_en      = 1'b1;
          count_next = count + 1'b1;
          state_next = last_q ? B_SOLVE : B_IDLE;
        end else begin
          state_next = B_INS_CMP;
        end
      end

      B_INS_CMP: begin
        kw_en = 1'b1;
        if (in_order) begin
          count_next = count + 1'b1;
          state_next = last_q ? B_SOLVE : B_IDLE;
        end else begin
          kw_data    = key_q;
          pos_next   = pos_m1;
          state_next = B_INS_RD;
        end
      end

      B_SOLVE: begin
        idx_next  = '0;
        prev_next = '0;
        if (count == '0) begin
          done_next   = 1'b1;
          result_next = '{best_total: '0, overflow: ovf};
          ovf_next    = 1'b0;
          state_next  = B_IDLE;
        end else begin
          state_next = B_DP_RD;
        end
      end

      B_DP_RD: begin
        kr_addr    = idx[IDX_W-1:0];
        state_next = B_DP_KEY;
      end

      B_DP_KEY: begin
        s_i_next   = key_q.start_time;
        take_next  = key_q.end_time - key_q.start_time;
        lo_next    = '0;
        hi_next    = idx;
        state_next = B_BS;
      end

      // binary search for the count of entries ending by s_i
      B_BS: begin
        kr_addr = mid[IDX_W-1:0];
        if (lo < hi) begin
          state_next = B_BS_CMP;
        end else if (lo != '0) begin
          state_next = B_BEST_WAIT;
        end else begin
          state_next = B_DP_UPD;
        end
      end

      B_BS_CMP: begin
        if (key_q.end_time <= s_i) begin
          lo_next = mid + 1'b1;
        end else begin
          hi_next = mid;
        end
        state_next = B_BS;
      end

      B_BEST_WAIT: begin
        take_next  = take + best_q;
        state_next = B_DP_UPD;
      end

      B_DP_UPD: begin
        bw_en     = 1'b1;
        prev_next = best_i;
        idx_next  = idx + 1'b1;
        if (idx + 1'b1 == count) begin
          done_next   = 1'b1;
          result_next = '{best_total: best_i, overflow: ovf};
          ovf_next    = 1'b0;
          count_next  = '0;
          state_next  = B_IDLE;
        end else begin
          state_next = B_DP_RD;
        end
      end

      default: state_next = B_IDLE;
    endcase
  end

endmodule

>>> bench/wisdp_checker.sv
module wisdp_checker import wisdp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  item_t   item,
  input  logic    done,
  input  result_t result,
  input  logic    cfg_we,
  input  logic    cfg_idx,
  input  time_t   cfg_data,
  output int      errors,
  output int      pending
);

  time_t   win_lo, win_hi;
  time_t   set_start[$];
  time_t   set_end[$];
  logic    set_ovf;
  result_t best_q[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch: %s got %0d want %0d", what, got, want);
    errors++;
  endtask

  // sort by end then start, then weighted interval DP on durations
  function automatic time_t best_schedule();
    time_t s[], e[], best[];
    time_t ts, te, take, skip;
    int    n, k, c;
    n = set_start.size();
    if (n == 0) return '0;
    s = new[n]; e = new[n]; best = new[n];
    for (int i = 0; i < n; i++) begin
      ts = set_start[i];
      te = set_end[i];
      k = i;
      while (k > 0 && (e[k-1] > te || (e[k-1] == te && s[k-1] > ts))) begin
        s[k] = s[k-1];
        e[k] = e[k-1];
        k--;
      end
      s[k] = ts;
      e[k] = te;
    end
    for (int i = 0; i < n; i++) begin
      c = 0;
      for (int j = 0; j < i; j++)
        if (e[j] <= s[i]) c = j + 1;
      take = e[i] - s[i];
      if (c > 0) take = take + best[c-1];
      skip = (i > 0) ? best[i-1] : '0;
      best[i] = (skip > take) ? skip : take;
    end
    return best[n-1];
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      win_lo = '0;
      win_hi = '1;
      set_start.delete();
      set_end.delete();
      set_ovf = 1'b0;
      best_q.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (best_q.size() == 0) begin
          report("result with none expected", 32'(result.best_total), 32'd0);
        end else begin
          want = best_q.pop_front();
          if (result.best_total !== want.best_total)
            report("best_total", 32'(result.best_total), 32'(want.best_total));
          if (result.overflow !== want.overflow)
            report("overflow", 32'(result.overflow), 32'(want.overflow));
        end
      end
      if (start && !busy) begin
        if (item.start_time >= win_lo && item.end_time <= win_hi &&
            item.end_time >= item.start_time) begin
          if (set_start.size() < MAX_INTERVALS) begin
            set_start.push_back(item.start_time);
            set_end.push_back(item.end_time);
          end else begin
            set_ovf = 1'b1;
          end
        end
        if (item.last_item) begin
          want.best_total = best_schedule();
          want.overflow   = set_ovf;
          best_q.push_back(want);
          set_start.delete();
          set_end.delete();
          set_ovf = 1'b0;
        end
      end
      if (cfg_we) begin
        if (cfg_idx == CFG_WINDOW_LOW) win_lo = cfg_data;
        else win_hi = cfg_data;
      end
    end
    pending = best_q.size();
  end

endmodule

>>> bench/tb_windowed_interval_schedule_dp.sv
module tb_windowed_interval_schedule_dp import wisdp_pkg::*;;

  // a full 1024-entry solve pass must finish well within this limit
  localparam int STALL_LIMIT = 200000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    done;
  result_t result;
  logic    cfg_we = 1'b0;
  logic    cfg_idx = 1'b0;
  time_t   cfg_data = '0;

  int errors, pending;
  int idle_pct;     // chance per request that start drops for a cycle
  int sent;         // requests accepted so far
  int quiet;        // cycles with no request accepted and no result
  int lo, hi;       // window as programmed, for shaping stimulus

  always #1 clk = ~clk;

  windowed_interval_schedule_dp i_dut (
    .clk, .rst, .start, .busy, .item, .done, .result,
    .cfg_we, .cfg_idx, .cfg_data
  );

  wisdp_checker i_chk (
    .clk, .rst, .start, .busy, .item, .done, .result,
    .cfg_we, .cfg_idx, .cfg_data, .errors, .pending
  );

  // watchdog: no request taken and no result for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("timeout");
      $display("FAIL windowed_interval_schedule_dp");
      $finish;
    end
  end

  // hold start until the block takes the request, then maybe idle
  task automatic send_interval(input int s, input int e, input bit last);
    item  <= '{start_time: time_t'(s), end_time: time_t'(e), last_item: last};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // block idle: every result in, then some slack for the insert engine
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_window(input int l, input int h);
    drain();
    cfg_we <= 1'b1; cfg_idx <= CFG_WINDOW_LOW; cfg_data <= time_t'(l);
    @(posedge clk);
    cfg_idx <= CFG_WINDOW_HIGH; cfg_data <= time_t'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    lo = l;
    hi = h;
  endtask

  // one set: mostly kept intervals, some reversed or outside the window
  task automatic random_set(input int n);
    int s, e, span, r;
    span = (hi >= lo) ? hi - lo : 0;
    if ($urandom_range(0, 3) != 0 && span > 2000) span = 2000;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        e = $urandom_range(0, 65534);
        s = $urandom_range(e + 1, 65535);
      end else if (r < 20) begin
        s = $urandom_range(0, 65535);
        e = $urandom_range(0, 65535);
      end else begin
        s = lo + $urandom_range(0, span);
        e = s + $urandom_range(0, span / 3 + 1);
        if (e > hi) e = hi;
        if (s > e) s = e;
      end
      send_interval(s, e, i == n - 1);
    end
  endtask

  initial begin
    lo = 0;
    hi = 65535;
    idle_pct = 11;
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty set: only a reversed interval
    send_interval(10, 5, 1);
    // full-range single interval, and zero-length extremes
    send_interval(0, 65535, 1);
    send_interval(0, 0, 0);
    send_interval(65535, 65535, 1);
    // ties, touching ends, overlaps, reversed in the middle
    send_interval(10, 20, 0);
    send_interval(10, 20, 0);
    send_interval(20, 30, 0);
    send_interval(40, 30, 0);
    send_interval(15, 30, 0);
    send_interval(5, 20, 1);
    // duration sum that reaches exactly the 16-bit maximum
    send_interval(0, 40000, 0);
    send_interval(40000, 65535, 1);

    // window edges: just outside on each side, then exactly on it
    set_window(100, 200);
    send_interval(99, 150, 0);
    send_interval(150, 201, 0);
    send_interval(100, 200, 1);
    // inverted window keeps nothing
    set_window(65535, 0);
    send_interval(0, 0, 0);
    send_interval(65535, 65535, 1);

    // store full: sorted input keeps insertion cheap
    set_window(0, 65535);
    for (int i = 0; i < MAX_INTERVALS + 4; i++)
      send_interval(i * 2, i * 2 + 1, i == MAX_INTERVALS + 3);
    // next set starts clean after the overflow
    send_interval(3, 9, 1);
    sent = 0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 11; set_window(0, 65535); end
        1: begin idle_pct = 60; set_window(300, 4000); end
        2: begin idle_pct = 0;  set_window(0, 65535); end
        default: begin
          idle_pct = 20;
          set_window($urandom_range(0, 65535), $urandom_range(0, 65535));
        end
      endcase
      while (sent < (ph + 1) * 140)
        random_set($urandom_range(1, 12));
    end

    drain();
    if (errors == 0) $display("PASS windowed_interval_schedule_dp");
    else $display("FAIL windowed_interval_schedule_dp");
    $finish;
  end

endmodule

>>> sim.f
sv/wisdp_pkg.sv
sv/wisdp_front.sv
sv/wisdp_back.sv
sv/windowed_interval_schedule_dp.sv
bench/wisdp_checker.sv
bench/tb_windowed_interval_schedule_dp.sv
